@@ design/etst_pkg.sv @@
package etst_pkg;

	localparam int SLOTS_DEF = 32;
	localparam int SLOT_W = 5;
	localparam int KEY_W = 6;
	localparam logic [KEY_W-1:0] KEY_NONE = 6'd32;

	localparam logic [31:0] EVT_WAIT_BIT = 32'h0000_0100;
	localparam logic [31:0] EVT_SIGNAL_BIT = 32'h0000_0200;
	localparam logic [31:0] EVT_EXIT_MASK = 32'h0000_0201;

	typedef enum logic [2:0] {
		CMD_CREATE = 3'd0,
		CMD_CLOSE = 3'd1,
		CMD_SIGNAL = 3'd2,
		CMD_SET_TIMER = 3'd3,
		CMD_CHECK = 3'd4,
		CMD_SIG_EXIT = 3'd5,
		CMD_TICK = 3'd6,
		CMD_BAD = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SUCCESS = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_RES = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	localparam logic [1:0] TK_CANCEL = 2'd0;
	localparam logic [1:0] TK_RELATIVE = 2'd1;
	localparam logic [1:0] TK_PERIODIC = 2'd2;
	localparam logic [1:0] TK_INVALID = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [4:0] slot_index;
		logic [31:0] event_type;
		logic has_notify;
		logic [1:0] timer_kind;
		logic [63:0] trigger_100ns;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] result_slot;
		logic notify_fire;
		logic last;
	} rsp_t;

	// one slot as it moves around the ring
	typedef struct packed {
		logic used;
		logic signaled;
		logic [31:0] flags;
		logic has_notify;
		logic armed;
		logic [63:0] deadline;
		logic [63:0] period;
	} slot_t;

endpackage

@@ design/etst_div10.sv @@
// Divide a 64-bit value by ten, sixteen bits per cycle by reciprocal multiplication.
module etst_div10 (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [63:0] dividend,
	output logic done,
	output logic [63:0] quotient
);
	import etst_pkg::*;

	logic [63:0] num_q;
	logic [63:0] quo_q;
	logic [3:0] rem_q;
	logic [1:0] cnt_q;
	logic run_q;
	logic [19:0] part;
	logic [15:0] qd;
	logic [19:0] back;
	logic [3:0] rem_n;

	// partial dividend: remainder so far over the next sixteen bits
	assign part = {rem_q, num_q[63:48]};
	// floor(part / 10) as (part * ceil(2^23 / 10)) >> 23, exact for part < 2^22
	assign qd = 16'(({20'd0, part} * 40'd838861) >> 23);
	assign back = 20'({qd, 3'b000}) + 20'({qd, 1'b0});
	assign rem_n = 4'(part - back);
	assign quotient = quo_q;

	// count four chunks, flag the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// shift in one quotient chunk per cycle
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[47:0], 16'd0};
			quo_q <= {quo_q[47:0], qd};
			rem_q <= rem_n;
		end
	end
endmodule

@@ design/etst_cell.sv @@
// One slot register of the ring; passes its slot to the next cell when shifting.
module etst_cell (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input etst_pkg::slot_t din,
	output etst_pkg::slot_t dout
);
	import etst_pkg::*;

	logic used_q;
	logic signaled_q;
	logic armed_q;
	logic [31:0] flags_q;
	logic has_notify_q;
	logic [63:0] deadline_q;
	logic [63:0] period_q;

	// pack in the field order of slot_t
	assign dout = {used_q, signaled_q, flags_q, has_notify_q, armed_q, deadline_q, period_q};

	// control bits reset, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			signaled_q <= 1'b0;
			armed_q <= 1'b0;
		end else if (shift) begin
			used_q <= din.used;
			signaled_q <= din.signaled;
			armed_q <= din.armed;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			flags_q <= din.flags;
			has_notify_q <= din.has_notify;
			deadline_q <= din.deadline;
			period_q <= din.period;
		end
	end
endmodule

@@ design/event_timer_slot_table.sv @@
// A command is taken at the accepting edge, rotates the ring once through all SLOTS
// cells in S_ROT, and then S_REPLY registers the last result.
// Set timer first passes through S_DIV for a divide by ten of its delay.
// Throughput: one command at a time, the next accepted while the last result shows.
// Reset clears all slots to unused, time to zero and the key wait slot to none.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module event_timer_slot_table #(
	parameter int SLOTS = etst_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input etst_pkg::req_t req,
	output logic rsp_valid,
	output etst_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [etst_pkg::KEY_W-1:0] cfg_wdata
);
	import etst_pkg::*;

	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_ROT, S_REPLY} state_t;

	state_t state_q;
	req_t req_q;
	logic [CW-1:0] pos_q;
	logic [KEY_W-1:0] key_q;
	logic [63:0] now_q;
	logic [63:0] us_q;
	logic found_q;
	logic [4:0] hit_q;
	logic [1:0] st_q;
	logic fire_q;

	slot_t ring [SLOTS];
	slot_t head, head_new;
	logic shift;
	logic div_go, div_done;
	logic [63:0] div_quo;

	logic hit;
	logic is_free, exit_fire, expired;
	logic [4:0] pos5;

	assign pos5 = SLOT_W'(pos_q);
	assign head = ring[SLOTS-1];
	assign shift = (state_q == S_ROT);
	assign busy = (state_q != S_IDLE);
	assign div_go = (state_q == S_IDLE) && start && (req.command == CMD_SET_TIMER);

	etst_div10 u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(req.trigger_100ns),
		.done(div_done), .quotient(div_quo)
	);

	// ring: cell 0 takes the modified head, the last cell is the head
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		etst_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift),
			.din(g == 0 ? head_new : ring[g-1]), .dout(ring[g])
		);
	end

	// the addressed slot passes the head while pos matches
	assign hit = ({{(32-CW){1'b0}}, pos_q} == {27'd0, req_q.slot_index});
	assign is_free = !head.used && !found_q;
	assign exit_fire = head.used && head.has_notify &&
		((head.flags & EVT_EXIT_MASK) == EVT_EXIT_MASK);
	assign expired = head.armed && (now_q >= head.deadline);

	// apply the command to the slot at the head
	always_comb begin
		head_new = head;
		case (req_q.command)
			CMD_CREATE: begin
				if (is_free) begin
					head_new.used = 1'b1;
					head_new.signaled = 1'b0;
					head_new.flags = req_q.event_type;
					head_new.has_notify = req_q.has_notify;
					head_new.armed = 1'b0;
					head_new.deadline = '0;
					head_new.period = '0;
				end
			end
			CMD_CLOSE: if (hit && head.used) head_new.used = 1'b0;
			CMD_SIGNAL: if (hit && head.used) head_new.signaled = 1'b1;
			CMD_SET_TIMER: begin
				if (hit && head.used && req_q.timer_kind != TK_INVALID) begin
					if (req_q.timer_kind == TK_CANCEL) begin
						head_new.armed = 1'b0;
						head_new.deadline = '0;
						head_new.period = '0;
					end else begin
						head_new.armed = 1'b1;
						head_new.deadline = now_q + us_q;
						head_new.period = (req_q.timer_kind == TK_PERIODIC) ? us_q : '0;
					end
				end
			end
			CMD_CHECK: begin
				if (hit && head.used && {1'b0, req_q.slot_index} != key_q) begin
					if (expired) begin
						if (head.period != '0) head_new.deadline = now_q + head.period;
						else begin
							head_new.armed = 1'b0;
							head_new.deadline = '0;
						end
					end
					head_new.signaled = 1'b0;
				end
			end
			CMD_SIG_EXIT: if (exit_fire) head_new.signaled = 1'b1;
			default: ;
		endcase
	end

	// sequencer: accept, divide for set timer, rotate the ring once, reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			key_q <= KEY_NONE;
			now_q <= '0;
			rsp_valid <= 1'b0;
			rsp <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			fire_q <= 1'b0;
			hit_q <= '0;
			st_q <= ST_INVALID;
		end else begin
			rsp_valid <= 1'b0;
			if (cfg_we) key_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pos_q <= '0;
						found_q <= 1'b0;
						fire_q <= 1'b0;
						hit_q <= '0;
						st_q <= ST_INVALID;
						if (req.command == CMD_SET_TIMER) state_q <= S_DIV;
						else state_q <= S_ROT;
					end
				end
				S_DIV: if (div_done) state_q <= S_ROT;
				S_ROT: begin
					pos_q <= pos_q + CW'(1);
					if (pos_q == CW'(SLOTS - 1)) state_q <= S_REPLY;
					case (req_q.command)
						CMD_CREATE: if (is_free) begin
							found_q <= 1'b1;
							hit_q <= pos5;
						end
						CMD_SIG_EXIT: if (exit_fire) begin
							rsp_valid <= 1'b1;
							rsp <= '{ST_SUCCESS, pos5, 1'b1, 1'b0};
						end
						CMD_CLOSE, CMD_SIGNAL, CMD_SET_TIMER: if (hit && head.used) begin
							if (req_q.command == CMD_SET_TIMER &&
									req_q.timer_kind == TK_INVALID) st_q <= ST_INVALID;
							else st_q <= ST_SUCCESS;
							if (req_q.command == CMD_SIGNAL)
								fire_q <= head.has_notify && ((head.flags & EVT_SIGNAL_BIT) != '0);
						end
						CMD_CHECK: if (hit && head.used) begin
							if (expired || head.signaled) st_q <= ST_SUCCESS;
							else begin
								st_q <= ST_NOT_READY;
								fire_q <= head.has_notify && ((head.flags & EVT_WAIT_BIT) != '0);
							end
						end
						default: ;
					endcase
				end
				S_REPLY: begin
					state_q <= S_IDLE;
					rsp_valid <= 1'b1;
					case (req_q.command)
						CMD_CREATE: begin
							if (found_q) rsp <= '{ST_SUCCESS, hit_q, 1'b0, 1'b1};
							else rsp <= '{ST_NO_RES, 5'd0, 1'b0, 1'b1};
						end
						CMD_CLOSE, CMD_SIGNAL, CMD_SET_TIMER:
							rsp <= '{st_q, req_q.slot_index, fire_q, 1'b1};
						CMD_CHECK: begin
							if ({1'b0, req_q.slot_index} == key_q)
								rsp <= '{ST_NOT_READY, req_q.slot_index, 1'b0, 1'b1};
							else rsp <= '{st_q, req_q.slot_index, fire_q, 1'b1};
						end
						CMD_SIG_EXIT, CMD_TICK: rsp <= '{ST_SUCCESS, 5'd0, 1'b0, 1'b1};
						default: rsp <= '{ST_INVALID, 5'd0, 1'b0, 1'b1};
					endcase
					if (req_q.command == CMD_TICK) now_q <= now_q + 64'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the request and the converted delay
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (div_done) us_q <= div_quo;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> !busy) else $error("last result while still busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.notify_fire) else $error("bad exit result");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !rsp_valid || $past(state_q) == S_REPLY)
		else $error("result outside a command");
endmodule
